// ----- rtl/core/bfoc_pkg.sv -----
`timescale 1ns / 1ps

package bfoc_pkg;

    // fixed field widths of one word
    localparam int unsigned START_W = 11;
    localparam int unsigned LEN_W   = 12;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned CBYTE_W = 8;
    // sum of start and length, and byte index up to the end of a claim
    localparam int unsigned SUM_W   = 13;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned FIRST_W = START_W - 3;
    localparam int unsigned WHOLE_W = LEN_W - 3;

    localparam logic [7:0] BYTE_FULL = 8'hff;

    typedef enum logic [STAT_W-1:0] {
        STS_OK        = 3'd0,
        STS_PAST_END  = 3'd1,
        STS_UNALIGNED = 3'd2,
        STS_NOT_BYTES = 3'd3,
        STS_OVERLAP   = 3'd4,
        STS_CROSSES   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_SHORT_RD,
        S_SHORT_CHK,
        S_RESP
    } t_state;

endpackage

// ----- rtl/core/bfoc_ram.sv -----
`timescale 1ns / 1ps

module bfoc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/bit_field_overlap_checker_unit.sv -----
`timescale 1ns / 1ps
// sequence: a rejected or zero-length word goes straight to its result; a short claim
//   reads its map byte, then checks and writes it; a long claim scans its N bytes
//   and marks them all if none is taken (one read, then one written, per cycle)
// throughput: one word at a time, the next taken after its result; a last entry
//   adds a clear of the whole map
// reset: synchronous, active low; the map is cleared after reset, accepting no word
module bit_field_overlap_checker_unit #(
    parameter int unsigned MAP_BYTES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [bfoc_pkg::START_W-1:0] i_start_bit,
    input  logic [bfoc_pkg::LEN_W-1:0]   i_field_length,
    input  logic                         i_last_entry,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [bfoc_pkg::STAT_W-1:0]  o_status,
    output logic [bfoc_pkg::CBYTE_W-1:0] o_conflict_byte
);

    import bfoc_pkg::*;

    localparam int unsigned AW = $clog2(MAP_BYTES);
    localparam logic [31:0] MAP_BITS = 32'(MAP_BYTES * 8);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAP_BYTES - 1);

    t_state r_state, n_state;
    t_status r_status, n_status;
    logic [CBYTE_W-1:0] r_conflict, n_conflict;
    logic [FIRST_W-1:0] r_first, n_first;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_end, n_end;
    logic [7:0]         r_mask, n_mask;
    logic               r_last, n_last;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic [AW-1:0]      r_clr, n_clr;

    logic               w_accept;
    logic [SUM_W-1:0]   w_sum;
    logic [2:0]         w_offset;
    logic [3:0]         w_short_end;
    logic [8:0]         w_ones;
    t_status            w_status;
    logic               w_long;

    logic               m_we;
    logic [AW-1:0]      m_waddr;
    logic [7:0]         m_wdata;
    logic [AW-1:0]      m_raddr;
    logic [7:0]         m_rdata;

    bfoc_ram #(
        .WIDTH(8),
        .DEPTH(MAP_BYTES)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    assign w_accept = i_valid && !o_stall;

    // claim decode, in order of error priority
    always_comb begin
        w_sum       = SUM_W'(i_start_bit) + SUM_W'(i_field_length);
        w_offset    = i_start_bit[2:0];
        w_short_end = {1'b0, w_offset} + i_field_length[3:0];
        w_ones      = (9'd1 << i_field_length[3:0]) - 9'd1;
        w_long      = (i_field_length[LEN_W-1:3] != '0);
        if (32'(w_sum) > MAP_BITS) begin
            w_status = STS_PAST_END;
        end else if (w_long && (w_offset != 3'd0)) begin
            w_status = STS_UNALIGNED;
        end else if (w_long && (i_field_length[2:0] != 3'd0)) begin
            w_status = STS_NOT_BYTES;
        end else if (!w_long && (w_short_end > 4'd8)) begin
            w_status = STS_CROSSES;
        end else begin
            w_status = STS_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (w_status != STS_OK || i_field_length == '0) begin
                        n_state = S_RESP;
                    end else if (w_long) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_SHORT_RD;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && m_rdata != 8'd0) begin
                    n_state = S_RESP;
                end else if (r_idx == r_end) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (r_idx == r_end) begin
                    n_state = S_RESP;
                end
            end
            S_SHORT_RD:  n_state = S_SHORT_CHK;
            S_SHORT_CHK: n_state = S_RESP;
            S_RESP: begin
                if (!i_stall) begin
                    n_state = r_last ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // outputs and map port
    always_comb begin
        o_stall = 1'b1;
        o_valid = 1'b0;
        m_we    = 1'b0;
        m_waddr = AW'(r_idx);
        m_wdata = BYTE_FULL;
        m_raddr = AW'(r_idx);
        unique case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = 8'd0;
            end
            S_IDLE: o_stall = 1'b0;
            S_SCAN: ;
            S_MARK: m_we = (r_idx != r_end);
            S_SHORT_RD: m_raddr = AW'(r_first);
            S_SHORT_CHK: begin
                m_we    = ((m_rdata & r_mask) == 8'd0);
                m_waddr = AW'(r_first);
                m_wdata = m_rdata | r_mask;
            end
            S_RESP: o_valid = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        n_status   = r_status;
        n_conflict = r_conflict;
        n_first    = r_first;
        n_idx      = r_idx;
        n_end      = r_end;
        n_mask     = r_mask;
        n_last     = r_last;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_clr      = r_clr;
        case (r_state)
            S_CLEAR: n_clr = r_clr + AW'(1);
            S_IDLE: begin
                n_clr      = '0;
                n_status   = w_status;
                n_conflict = '0;
                n_first    = i_start_bit[START_W-1:3];
                n_idx      = IDX_W'(i_start_bit[START_W-1:3]);
                n_end      = IDX_W'(i_start_bit[START_W-1:3])
                             + IDX_W'(i_field_length[LEN_W-1:3]);
                n_mask     = w_ones[7:0] << w_offset;
                n_last     = i_last_entry;
                n_pend     = 1'b0;
            end
            S_SCAN: begin
                if (r_pend && m_rdata != 8'd0) begin
                    n_status   = STS_OVERLAP;
                    n_conflict = r_pidx[CBYTE_W-1:0];
                end else if (r_idx != r_end) begin
                    // read this byte, check it next cycle
                    n_pidx = r_idx;
                    n_pend = 1'b1;
                    n_idx  = r_idx + IDX_W'(1);
                end else begin
                    n_idx = IDX_W'(r_first);
                end
            end
            S_MARK: begin
                if (r_idx != r_end) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_SHORT_CHK: begin
                if ((m_rdata & r_mask) != 8'd0) begin
                    n_status   = STS_OVERLAP;
                    n_conflict = r_first[CBYTE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_conflict <= n_conflict;
        r_first    <= n_first;
        r_idx      <= n_idx;
        r_end      <= n_end;
        r_mask     <= n_mask;
        r_pidx     <= n_pidx;
    end

    assign o_status        = r_status;
    assign o_conflict_byte = r_conflict;

endmodule

// ----- rtl/core/bfoc_checker.sv -----
`timescale 1ns / 1ps

module bfoc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [bfoc_pkg::START_W-1:0] i_start_bit,
    input logic [bfoc_pkg::LEN_W-1:0]   i_field_length,
    input logic                         i_last_entry,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [bfoc_pkg::STAT_W-1:0]  o_status,
    input logic [bfoc_pkg::CBYTE_W-1:0] o_conflict_byte
);

    import bfoc_pkg::*;

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_conflict_byte))
        else $error("result word changed under stall");

    // conflict index is only reported on overlap
    a_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STS_OVERLAP |-> o_conflict_byte == '0)
        else $error("conflict byte set without overlap");

    // one word in flight: no input taken while a result waits
    a_busy_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input ready while result pending");

    // an accepted word keeps the input stalled until its result is out
    a_busy_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input ready right after accepting a word");

    // no result word without a word having been taken earlier
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall || i_valid))
        else $error("result appeared while idle");

endmodule

bind bit_field_overlap_checker_unit bfoc_checker u_bfoc_checker (.*);

// ----- tb/bit_field_overlap_checker_unit_tb.sv -----
`timescale 1ns / 1ps

module bit_field_overlap_checker_unit_tb;
    import bfoc_pkg::*;

    localparam int unsigned MAP_BYTES   = 256;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned RAND_WORDS  = 600;

    typedef struct {
        t_status            status;
        logic [CBYTE_W-1:0] cbyte;
    } claim_verdict_t;

    typedef struct {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               last;
        bit                 typed;
        t_status            status;
        logic [CBYTE_W-1:0] cbyte;
    } claim_row_t;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic [START_W-1:0] i_start_bit    = '0;
    logic [LEN_W-1:0]   i_field_length = '0;
    logic               i_last_entry   = 1'b0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [CBYTE_W-1:0] o_conflict_byte;

    logic [7:0]     shadow_map [0:MAP_BYTES-1];
    claim_verdict_t claim_verdicts [$];
    claim_row_t     dir_rows [$];
    claim_verdict_t seen_want;
    bit             no_idle   = 1'b0;
    int             fault_cnt = 0;
    int             hold_cnt  = 0;
    int unsigned    cycle_cnt = 0;

    bit_field_overlap_checker_unit #(
        .MAP_BYTES(MAP_BYTES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_start_bit    (i_start_bit),
        .i_field_length (i_field_length),
        .i_last_entry   (i_last_entry),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_conflict_byte(o_conflict_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow occupancy map, updated as each word is taken
    function automatic void judge_claim(input logic [START_W-1:0] sb,
                                        input logic [LEN_W-1:0] len, input logic last,
                                        output t_status st, output logic [CBYTE_W-1:0] cb);
        int unsigned s, n, first, offset, whole, stop, i;
        logic [7:0]  mask;
        bit          hit;
        s      = sb;
        n      = len;
        first  = s >> 3;
        offset = s & 7;
        whole  = n >> 3;
        st     = STS_OK;
        cb     = '0;
        hit    = 1'b0;
        if (s + n > MAP_BYTES * 8) begin
            st = STS_PAST_END;
        end else if (whole != 0) begin
            if (offset != 0) begin
                st = STS_UNALIGNED;
            end else if ((n & 7) != 0) begin
                st = STS_NOT_BYTES;
            end else begin
                stop = first + whole;
                for (i = first; i < stop && !hit; i++) begin
                    if (shadow_map[i] != 8'h00) begin
                        hit = 1'b1;
                        cb  = i[7:0];
                    end
                end
                if (hit) begin
                    st = STS_OVERLAP;
                end else begin
                    for (i = first; i < stop; i++) shadow_map[i] = BYTE_FULL;
                end
            end
        end else if (n > 8 - offset) begin
            st = STS_CROSSES;
        end else if (n != 0) begin
            mask = 8'(((1 << n) - 1) << offset);
            if ((shadow_map[first] & mask) != 8'h00) begin
                st = STS_OVERLAP;
                cb = first[7:0];
            end else begin
                shadow_map[first] = shadow_map[first] | mask;
            end
        end
        // a rejected last word still wipes the map
        if (last) begin
            for (i = 0; i < MAP_BYTES; i++) shadow_map[i] = 8'h00;
        end
    endfunction

    task automatic offer_claim(input logic [START_W-1:0] sb, input logic [LEN_W-1:0] len,
                               input logic last, input bit typed, input t_status st_t,
                               input logic [CBYTE_W-1:0] cb_t);
        int                 gap;
        t_status            st;
        logic [CBYTE_W-1:0] cb;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_start_bit    <= sb;
        i_field_length <= len;
        i_last_entry   <= last;
        do @(posedge i_clk); while (o_stall);
        judge_claim(sb, len, last, st, cb);
        if (typed) begin
            claim_verdicts.push_back('{st_t, cb_t});
        end else begin
            claim_verdicts.push_back('{st, cb});
        end
    endtask

    task automatic drain_verdicts();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (claim_verdicts.size() != 0);
    endtask

    // result side: check each word and hold stall for a drawn number of valid cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (claim_verdicts.size() == 0) begin
                    $error("status: expected none, got %0d", o_status);
                    fault_cnt++;
                end else begin
                    seen_want = claim_verdicts.pop_front();
                    if (o_status !== seen_want.status) begin
                        $error("status: expected %0d, got %0d", seen_want.status, o_status);
                        fault_cnt++;
                    end
                    if (o_conflict_byte !== seen_want.cbyte) begin
                        $error("conflict_byte: expected %0d, got %0d", seen_want.cbyte,
                               o_conflict_byte);
                        fault_cnt++;
                    end
                end
                hold_cnt = no_idle ? 0 : $urandom_range(0, 6);
            end else if (o_valid && hold_cnt != 0) begin
                hold_cnt--;
            end
            i_stall <= (hold_cnt != 0);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int unsigned        sent, tbl_len, k, kind, byte_idx, nbytes, off;
        logic [START_W-1:0] sb;
        logic [LEN_W-1:0]   len;
        logic               last;
        bit                 paused;

        for (int m = 0; m < MAP_BYTES; m++) shadow_map[m] = 8'h00;

        // typed rows: reset state, extremes and error priority
        dir_rows.push_back('{11'd0,    12'd8,    1'b0, 1'b1, STS_OK,        8'd0});
        dir_rows.push_back('{11'd0,    12'd8,    1'b0, 1'b1, STS_OVERLAP,   8'd0});
        dir_rows.push_back('{11'd2047, 12'd1,    1'b0, 1'b1, STS_OK,        8'd0});
        dir_rows.push_back('{11'd2047, 12'd2,    1'b0, 1'b1, STS_PAST_END,  8'd0});
        dir_rows.push_back('{11'd0,    12'd2048, 1'b0, 1'b1, STS_OVERLAP,   8'd0});
        dir_rows.push_back('{11'd1,    12'd4095, 1'b0, 1'b1, STS_PAST_END,  8'd0});
        dir_rows.push_back('{11'd3,    12'd16,   1'b0, 1'b1, STS_UNALIGNED, 8'd0});
        dir_rows.push_back('{11'd8,    12'd12,   1'b0, 1'b1, STS_NOT_BYTES, 8'd0});
        dir_rows.push_back('{11'd6,    12'd3,    1'b0, 1'b1, STS_CROSSES,   8'd0});
        dir_rows.push_back('{11'd4,    12'd12,   1'b0, 1'b1, STS_UNALIGNED, 8'd0});
        dir_rows.push_back('{11'd2040, 12'd9,    1'b0, 1'b1, STS_PAST_END,  8'd0});
        dir_rows.push_back('{11'd16,   12'd0,    1'b0, 1'b1, STS_OK,        8'd0});
        dir_rows.push_back('{11'd2047, 12'd0,    1'b0, 1'b1, STS_OK,        8'd0});
        // predicted rows
        dir_rows.push_back('{11'd8,    12'd4,    1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd10,   12'd2,    1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd12,   12'd4,    1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd0,    12'd64,   1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd16,   12'd64,   1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd0,    12'd2048, 1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd5,    12'd3,    1'b1, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd0,    12'd2048, 1'b1, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd0,    12'd2048, 1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd2040, 12'd8,    1'b0, 1'b0, STS_OK,        8'd0});
        dir_rows.push_back('{11'd1,    12'd7,    1'b1, 1'b0, STS_OK,        8'd0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            offer_claim(dir_rows[r].start, dir_rows[r].len, dir_rows[r].last,
                        dir_rows[r].typed, dir_rows[r].status, dir_rows[r].cbyte);
        end
        drain_verdicts();

        sent   = 0;
        paused = 1'b0;
        while (sent < RAND_WORDS) begin
            tbl_len = $urandom_range(1, 24);
            no_idle = ($urandom_range(0, 4) == 0);
            for (k = 0; k < tbl_len; k++) begin
                kind     = $urandom_range(0, 99);
                byte_idx = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(0, 255);
                last     = (k == tbl_len - 1);
                if (kind < 45) begin
                    // whole bytes, mostly short runs so overlaps stay likely
                    nbytes = ($urandom_range(0, 49) == 0) ? $urandom_range(1, 256)
                                                          : $urandom_range(1, 8);
                    sb  = START_W'(byte_idx * 8);
                    len = LEN_W'(nbytes * 8);
                end else if (kind < 85) begin
                    off = $urandom_range(0, 7);
                    sb  = START_W'(byte_idx * 8 + off);
                    len = LEN_W'($urandom_range(1, 8 - off));
                end else begin
                    sb  = START_W'($urandom_range(0, 2047));
                    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 4095))
                                                      : LEN_W'($urandom_range(0, 24));
                    if ($urandom_range(0, 9) == 0) last = 1'b1;
                end
                offer_claim(sb, len, last, 1'b0, STS_OK, '0);
                sent++;
                if (!paused && sent >= RAND_WORDS / 2) begin
                    paused = 1'b1;
                    drain_verdicts();
                end
            end
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;

        do @(posedge i_clk); while (claim_verdicts.size() != 0);
        repeat (32) @(posedge i_clk);

        if (fault_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
